FILE: sv/mcde_pkg.sv
// Shared constants for the memory copy DMA engine.
// No dependencies; used by the channel interfaces and the top level.
package mcde_pkg;

    // Width of the word count in a copy command and in the poll value.
    localparam int COUNT_W = 16;

endpackage

FILE: sv/mcde_if.sv
// Channel interfaces of the memory copy DMA engine: one tick request in,
// one memory request result out. Depends on mcde_pkg for the count width.

// One clock tick of the memory port seen by the engine.
interface mcde_tick_if #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          cpu_mem_busy;
    logic                          cmd_valid;
    logic [ADDR_WIDTH-1:0]         cmd_source;
    logic [ADDR_WIDTH-1:0]         cmd_dest;
    logic [mcde_pkg::COUNT_W-1:0]  cmd_count;
    logic [DATA_WIDTH-1:0]         read_data;

    modport source (
        output valid, cpu_mem_busy, cmd_valid, cmd_source, cmd_dest, cmd_count,
               read_data,
        input  ready
    );
    modport sink (
        input  valid, cpu_mem_busy, cmd_valid, cmd_source, cmd_dest, cmd_count,
               read_data,
        output ready
    );
endinterface

// Memory requests and poll value produced for one tick.
interface mcde_result_if #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          mem_read;
    logic [ADDR_WIDTH-1:0]         mem_read_addr;
    logic                          mem_write;
    logic [ADDR_WIDTH-1:0]         mem_write_addr;
    logic [DATA_WIDTH-1:0]         mem_write_data;
    logic [mcde_pkg::COUNT_W-1:0]  words_left;

    modport source (
        output valid, mem_read, mem_read_addr, mem_write, mem_write_addr,
               mem_write_data, words_left,
        input  ready
    );
    modport sink (
        input  valid, mem_read, mem_read_addr, mem_write, mem_write_addr,
               mem_write_data, words_left,
        output ready
    );
endinterface

FILE: sv/memory_copy_dma_engine_unit.sv
// Memory copy DMA engine: an accepted tick request has its result in the output
// register in the next cycle; throughput is one tick per cycle.
// A tick is accepted while the output register is empty or drains that cycle,
// so only a result held by a downstream stall holds off the next tick.
// Reset (synchronous, i_rst_n low) clears pointers, count, held word, the
// read/write phase flags and the output valid. Depends on mcde_pkg and mcde_if.sv.
module memory_copy_dma_engine_unit #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcde_tick_if.sink     i_tick,
    mcde_result_if.source o_res
);

    localparam int CW = mcde_pkg::COUNT_W;

    // Engine state.
    logic [ADDR_WIDTH-1:0] r_src, n_src;
    logic [ADDR_WIDTH-1:0] r_dst, n_dst;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_held, n_held;
    logic                  r_rd_out, n_rd_out;
    logic                  r_wr_pend, n_wr_pend;

    // Output register.
    logic                  r_out_valid;
    logic                  r_mem_read;
    logic [ADDR_WIDTH-1:0] r_mem_read_addr;
    logic                  r_mem_write;
    logic [ADDR_WIDTH-1:0] r_mem_write_addr;
    logic [DATA_WIDTH-1:0] r_mem_write_data;
    logic [CW-1:0]         r_words_left;

    logic tick_acc;
    logic do_read;
    logic do_write;

    // Accept a tick when the result slot is free or drains this cycle.
    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign tick_acc     = i_tick.valid && i_tick.ready;

    // Read only when the port is free and idle between words; write whenever a word is held and the port is free.
    assign do_read  = !i_tick.cpu_mem_busy && (r_cnt != '0) && !r_rd_out && !r_wr_pend;
    assign do_write = !i_tick.cpu_mem_busy && r_wr_pend;

    // Next state for one tick.
    always_comb begin
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_held    = r_held;
        n_rd_out  = 1'b0;
        n_wr_pend = r_wr_pend;

        // A command is taken only with no copy in progress and the port free.
        if (i_tick.cmd_valid && !i_tick.cpu_mem_busy && (r_cnt == '0)) begin
            n_src = i_tick.cmd_source;
            n_dst = i_tick.cmd_dest;
            n_cnt = i_tick.cmd_count;
        end

        if (do_read) begin
            n_src    = r_src + ADDR_WIDTH'(1);
            n_rd_out = 1'b1;
        end

        // Data of last tick's read has returned, even if the processor is busy.
        if (r_rd_out) begin
            n_held    = i_tick.read_data;
            n_wr_pend = 1'b1;
        end

        if (do_write) begin
            n_dst     = r_dst + ADDR_WIDTH'(1);
            n_cnt     = r_cnt - CW'(1);
            n_wr_pend = 1'b0;
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src     <= '0;
            r_dst     <= '0;
            r_cnt     <= '0;
            r_held    <= '0;
            r_rd_out  <= 1'b0;
            r_wr_pend <= 1'b0;
        end else if (tick_acc) begin
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_cnt     <= n_cnt;
            r_held    <= n_held;
            r_rd_out  <= n_rd_out;
            r_wr_pend <= n_wr_pend;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; unused request fields read as zero.
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_mem_read       <= do_read;
            r_mem_read_addr  <= do_read ? r_src : '0;
            r_mem_write      <= do_write;
            r_mem_write_addr <= do_write ? r_dst : '0;
            r_mem_write_data <= do_write ? r_held : '0;
            r_words_left     <= r_cnt;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.mem_read       = r_mem_read;
    assign o_res.mem_read_addr  = r_mem_read_addr;
    assign o_res.mem_write      = r_mem_write;
    assign o_res.mem_write_addr = r_mem_write_addr;
    assign o_res.mem_write_data = r_mem_write_data;
    assign o_res.words_left     = r_words_left;

    // A read and a write are never requested in the same tick.
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_mem_read && r_mem_write))
        else $error("read and write requested in one tick");

    // The word phases never overlap.
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_out && r_wr_pend))
        else $error("read outstanding while a write is pending");

    // A word in flight always belongs to a copy with words left.
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_out || r_wr_pend) |-> (r_cnt != '0))
        else $error("word in flight with zero count");

    // Each write retires exactly one word.
    a_cnt_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && do_write) |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("count not decremented on write");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for memory_copy_dma_engine_unit: drives random and
// directed tick requests, predicts every memory request, compares field by field.
// Depends on mcde_pkg, the channel interfaces in mcde_if.sv and the top level.
module tb_top;

    localparam int AW         = 16;
    localparam int DW         = 32;
    localparam int CW         = mcde_pkg::COUNT_W;
    localparam int RAND_ITEMS = 600;
    localparam int TAIL_ITEMS = 80;
    localparam int LIMIT      = 200000;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 80;

    // One tick request as queued for the driver.
    typedef struct packed {
        logic          busy;
        logic          cmd;
        logic [AW-1:0] src;
        logic [AW-1:0] dst;
        logic [CW-1:0] cnt;
        logic [DW-1:0] rdata;
        logic          drain;
    } t_tick_req;

    // Memory request and poll value produced for one tick.
    typedef struct packed {
        logic          rd;
        logic [AW-1:0] rd_addr;
        logic          wr;
        logic [AW-1:0] wr_addr;
        logic [DW-1:0] wr_data;
        logic [CW-1:0] words_left;
    } t_mem_req;

    logic i_clk;
    logic i_rst_n;

    mcde_tick_if   #(.ADDR_WIDTH(AW), .DATA_WIDTH(DW)) tick_bus ();
    mcde_result_if #(.ADDR_WIDTH(AW), .DATA_WIDTH(DW)) res_bus ();

    memory_copy_dma_engine_unit #(.ADDR_WIDTH(AW), .DATA_WIDTH(DW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_bus.sink),
        .o_res   (res_bus.source)
    );

    t_tick_req pending_ticks[$];
    t_mem_req  expected_reqs[$];
    t_tick_req cur_tick;
    int        fail_count   = 0;
    int        results_seen = 0;
    int        gap_left     = 0;
    int        stall_left   = 0;
    int        hold_left    = 0;
    logic      hold_done    = 1'b0;
    logic      tail_phase   = 1'b0;
    logic      drain_next   = 1'b0;

    // Predicted engine state.
    logic [AW-1:0] copy_src_ptr  = '0;
    logic [AW-1:0] copy_dst_ptr  = '0;
    logic [CW-1:0] copy_left     = '0;
    logic [DW-1:0] copy_held     = '0;
    logic          read_in_flight = 1'b0;
    logic          write_waiting  = 1'b0;

    // Clock and the single reset pulse.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n               = 1'b0;
        tick_bus.valid        = 1'b0;
        tick_bus.cpu_mem_busy = 1'b0;
        tick_bus.cmd_valid    = 1'b0;
        tick_bus.cmd_source   = '0;
        tick_bus.cmd_dest     = '0;
        tick_bus.cmd_count    = '0;
        tick_bus.read_data    = '0;
        res_bus.ready         = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Advance the predicted engine by one tick and return its memory request.
    task automatic step_copy_engine(input t_tick_req t, output t_mem_req r);
        logic          do_rd;
        logic          do_wr;
        logic [AW-1:0] n_src;
        logic [AW-1:0] n_dst;
        logic [CW-1:0] n_cnt;
        logic [DW-1:0] n_held;
        logic          n_wait;
        do_rd = !t.busy && (copy_left != '0) && !read_in_flight && !write_waiting;
        do_wr = !t.busy && write_waiting;

        r.rd         = do_rd;
        r.rd_addr    = do_rd ? copy_src_ptr : '0;
        r.wr         = do_wr;
        r.wr_addr    = do_wr ? copy_dst_ptr : '0;
        r.wr_data    = do_wr ? copy_held : '0;
        r.words_left = copy_left;

        n_src  = copy_src_ptr;
        n_dst  = copy_dst_ptr;
        n_cnt  = copy_left;
        n_held = copy_held;
        n_wait = write_waiting;
        // A command loads only when idle and the memory port is ours.
        if (t.cmd && !t.busy && copy_left == '0) begin
            n_src = t.src;
            n_dst = t.dst;
            n_cnt = t.cnt;
        end
        if (do_rd) n_src = copy_src_ptr + AW'(1);
        // Read data returns one tick later, even while the processor is busy.
        if (read_in_flight) begin
            n_held = t.rdata;
            n_wait = 1'b1;
        end
        if (do_wr) begin
            n_dst  = copy_dst_ptr + AW'(1);
            n_cnt  = copy_left - CW'(1);
            n_wait = 1'b0;
        end
        copy_src_ptr   = n_src;
        copy_dst_ptr   = n_dst;
        copy_left      = n_cnt;
        copy_held      = n_held;
        read_in_flight = do_rd;
        write_waiting  = n_wait;
    endtask

    task automatic push_tick(input logic busy, input logic cmd, input logic [AW-1:0] src,
                             input logic [AW-1:0] dst, input logic [CW-1:0] cnt);
        t_tick_req t;
        t.busy      = busy;
        t.cmd       = cmd;
        t.src       = src;
        t.dst       = dst;
        t.cnt       = cnt;
        t.rdata     = DW'($urandom);
        t.drain     = drain_next;
        drain_next  = 1'b0;
        pending_ticks.push_back(t);
    endtask

    // Addresses favor the ends of the space so that pointers wrap.
    function automatic logic [AW-1:0] pick_addr();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1 - AW'($urandom_range(0, 4));
            default: return AW'($urandom);
        endcase
    endfunction

    // A copy command followed by enough ticks to finish it. Ignored commands
    // are mixed in only where the engine is sure to be busy or still copying.
    task automatic add_copy_run(input logic [AW-1:0] src, input logic [AW-1:0] dst,
                                input int cnt, input int busy_pct);
        int  free_ticks;
        logic noise;
        free_ticks = 3 * cnt + 1;
        push_tick(1'b0, 1'b1, src, dst, CW'(cnt));
        for (int k = 1; k <= free_ticks; k++) begin
            while ($urandom_range(0, 99) < busy_pct)
                push_tick(1'b1, 1'($urandom_range(0, 1)), AW'($urandom), AW'($urandom),
                          CW'($urandom));
            noise = (k <= 2 * cnt - 1) && ($urandom_range(0, 3) == 0);
            push_tick(1'b0, noise, AW'($urandom), AW'($urandom), CW'($urandom));
        end
    endtask

    // Queue the directed part, then the random part.
    initial begin : fill_stimulus
        int   cnt;
        int   busy_pct;
        logic drain_placed;
        drain_placed = 1'b0;
        // Idle tick with every field at its low end.
        pending_ticks.push_back('0);
        // Command while the processor is busy, every field at its high end.
        pending_ticks.push_back('1 & ~t_tick_req'(1));
        push_tick(1'b0, 1'b0, '0, '0, '0);
        // Zero-count command loads pointers and copies nothing.
        push_tick(1'b0, 1'b1, 16'h1234, 16'habcd, '0);
        push_tick(1'b0, 1'b0, '0, '0, '0);
        // Single word at address zero, then a wrapping copy with busy pauses.
        add_copy_run('0, '0, 1, 0);
        add_copy_run('1, '1 - AW'(1), 3, 40);

        while (pending_ticks.size() < RAND_ITEMS) begin
            // Once, midway, the sender waits for every result before going on.
            if (!drain_placed && pending_ticks.size() > RAND_ITEMS / 2) begin
                drain_next   = 1'b1;
                drain_placed = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                // Stray ticks between copies; commands only while busy.
                repeat ($urandom_range(1, 4))
                    push_tick(1'($urandom_range(0, 1)), 1'b0, AW'($urandom),
                              AW'($urandom), CW'($urandom));
                push_tick(1'b1, 1'b1, AW'($urandom), AW'($urandom), CW'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0)
                    cnt = 0;
                else if ($urandom_range(0, 7) == 0)
                    cnt = $urandom_range(5, 12);
                else
                    cnt = $urandom_range(1, 4);
                case ($urandom_range(0, 3))
                    0:       busy_pct = 0;
                    1:       busy_pct = 10;
                    2:       busy_pct = 30;
                    default: busy_pct = 60;
                endcase
                add_copy_run(pick_addr(), pick_addr(), cnt, busy_pct);
            end
        end
    end

    // Driver: presents queued ticks, predicts each accepted one.
    always @(posedge i_clk) begin : tick_driver
        t_mem_req pred;
        logic     offer;
        if (!i_rst_n) begin
            tick_bus.valid <= 1'b0;
        end else begin
            if (tick_bus.valid && tick_bus.ready) begin
                step_copy_engine(cur_tick, pred);
                expected_reqs.push_back(pred);
            end
            if (pending_ticks.size() < TAIL_ITEMS) tail_phase = 1'b1;
            if (!tick_bus.valid || tick_bus.ready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ticks.size() > 0) begin
                    if (pending_ticks[0].drain && expected_reqs.size() != 0) begin
                        // Hold the next request until every result is back.
                    end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(1, 12) - 1;
                    end else begin
                        cur_tick = pending_ticks.pop_front();
                        offer    = 1'b1;
                    end
                end
                tick_bus.valid <= offer;
                if (offer) begin
                    tick_bus.cpu_mem_busy <= cur_tick.busy;
                    tick_bus.cmd_valid    <= cur_tick.cmd;
                    tick_bus.cmd_source   <= cur_tick.src;
                    tick_bus.cmd_dest     <= cur_tick.dst;
                    tick_bus.cmd_count    <= cur_tick.cnt;
                    tick_bus.read_data    <= cur_tick.rdata;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_mem_req want;
        logic     rdy;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_reqs.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_reqs.pop_front();
                    check_field("mem_read", 64'(want.rd), 64'(res_bus.mem_read));
                    check_field("mem_read_addr", 64'(want.rd_addr),
                                64'(res_bus.mem_read_addr));
                    check_field("mem_write", 64'(want.wr), 64'(res_bus.mem_write));
                    check_field("mem_write_addr", 64'(want.wr_addr),
                                64'(res_bus.mem_write_addr));
                    check_field("mem_write_data", 64'(want.wr_data),
                                64'(res_bus.mem_write_data));
                    check_field("words_left", 64'(want.words_left),
                                64'(res_bus.words_left));
                end
                results_seen++;
                if (results_seen == HOLD_AT && !hold_done) begin
                    hold_left = HOLD_LEN;
                    hold_done = 1'b1;
                end
            end
            rdy = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                rdy = 1'b0;
            end
            res_bus.ready <= rdy;
        end
    end

    // End of run: wait for all results or the timeout, then report the verdict.
    initial begin : run_control
        int cycles;
        cycles = 0;
        @(posedge i_rst_n);
        while (!(pending_ticks.size() == 0 && !tick_bus.valid && expected_reqs.size() == 0)
                && cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (8) @(posedge i_clk);
            if (fail_count == 0 && expected_reqs.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
